[design/rftt_pkg.sv]
// Shared types and constants for the radar frame target tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package rftt_pkg;

    localparam int NUM_SLOTS  = 10;
    localparam int MAX_STAGED = 8;

    localparam int BASE_LEN  = 14;
    localparam int REC_LEN   = 8;
    localparam int REC_START = 12;
    localparam int COUNT_POS = 5;

    localparam int POS_W  = 12;
    localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    // Queue word. Target record: id, distance, pitch, yaw.
    // Frame end: id holds the count byte, distance[0] the count-overflow error.
    typedef struct packed {
        logic       is_end;
        logic [7:0] id;
        logic [7:0] distance;
        logic [7:0] pitch;
        logic [7:0] yaw;
    } t_qent;

    typedef struct packed {
        logic       pad;
        logic       frame_error;
        logic [7:0] frame_count_field;
        logic [7:0] prev_yaw;
        logic [7:0] prev_pitch;
        logic [7:0] prev_distance;
        logic       prev_valid;
        logic [7:0] yaw;
        logic [7:0] pitch;
        logic [7:0] distance;
        logic       present;
        logic [3:0] slot;
    } t_out;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [0:0] {
        B_APPLY,
        B_REPORT
    } t_bstate;

endpackage

`default_nettype wire

[design/radar_frame_target_tracker.sv]
// Radar frame target tracker: top level joining parser, queue and slot updater.
// Depends on rftt_pkg, rftt_front, rftt_queue, rftt_back.
//
// Usage:
//   Slave channel takes one received radar byte per word. The parser keeps the
//   frame position; byte 5 sets the length to 14 + 8 * count. Each complete
//   target record among the first 8 (first four bytes) is queued for the updater.
//   When the last frame byte is taken, a frame-end mark is queued.
//   The updater applies one queued record per cycle, then on the frame-end mark
//   reports every slot, one master word per ready cycle, tlast on the final slot.
// Throughput: one input byte per cycle while the 4-entry queue has room.
//   The updater takes each staged record (at most 8) and the frame-end mark,
//   then walks one report per slot.
// Report path: when the frame-end mark leaves the queue, the updater enters
//   B_REPORT and loads the first slot report into the output register.
// Reset (synchronous, active low): position 0, length 14, all slots absent,
//   all current and previous positions zero, previous-valid bits clear.
// Stall: a stalled master holds its word; the slot walk waits, the queue fills,
//   and then o_s_tready drops until the walk ends and the updater pops again.
`default_nettype none

module radar_frame_target_tracker import rftt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [3:0] slot, [4] present, [12:5] distance, [20:13] pitch, [28:21] yaw,
    // [29] prev_valid, [37:30] prev_distance, [45:38] prev_pitch,
    // [53:46] prev_yaw, [61:54] frame_count_field, [62] frame_error, [63] zero
    output logic [63:0]      o_m_tdata,
    output logic             o_m_tlast    // last
);

    t_qstat qstat;
    t_qent  push_ent, pop_ent;
    logic   push, pop;

    rftt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_tdata  (i_s_tdata),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_ent    (push_ent)
    );

    rftt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .i_pop   (pop),
        .o_ent   (pop_ent),
        .o_qstat (qstat)
    );

    rftt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ent    (pop_ent),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[3:0] == 4'(NUM_SLOTS - 1))
        else $error("tlast on a slot other than the final one");

    a_slot_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
            o_m_tvalid && o_m_tdata[3:0] == $past(o_m_tdata[3:0]) + 4'd1)
        else $error("slot walk skipped or stalled mid-frame");

    a_prev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[29] |-> o_m_tdata[53:30] == 24'd0)
        else $error("previous position set without previous-valid");

endmodule

`default_nettype wire

[design/rftt_front.sv]
// Byte parser: tracks frame position and length, assembles target records.
// Depends on rftt_pkg; feeds rftt_queue.
`default_nettype none

module rftt_front import rftt_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_tvalid,
    output logic            o_tready,
    input  wire logic [7:0] i_tdata,
    input  wire t_qstat     i_qstat,
    output logic            o_push,
    output t_qent           o_ent
);

    logic [POS_W-1:0] r_pos, r_len;
    logic [7:0]       r_count;
    logic             r_err;
    logic [7:0]       r_id, r_dist, r_pitch;

    logic             accept;
    logic [POS_W-1:0] pos_inc, rel, len_eff, idx;
    logic [2:0]       off;
    logic             at_count, in_rec, frame_end, err_eff;
    logic [7:0]       cnt_eff;

    always_comb begin
        accept    = i_tvalid && !i_qstat.full;
        pos_inc   = r_pos + POS_W'(1);
        rel       = r_pos - POS_W'(REC_START);
        idx       = rel / POS_W'(REC_LEN);
        off       = 3'(rel % POS_W'(REC_LEN));
        at_count  = r_pos == POS_W'(COUNT_POS);
        len_eff   = at_count ? POS_W'(BASE_LEN) + POS_W'(i_tdata) * POS_W'(REC_LEN) : r_len;
        cnt_eff   = at_count ? i_tdata : r_count;
        err_eff   = at_count ? (i_tdata > 8'(MAX_STAGED)) : r_err;
        in_rec    = (r_pos >= POS_W'(REC_START)) && (idx < POS_W'(MAX_STAGED));
        frame_end = pos_inc == len_eff;

        o_ent.is_end = frame_end;
        if (frame_end) begin
            o_ent.id       = cnt_eff;
            o_ent.distance = {7'd0, err_eff};
            o_ent.pitch    = 8'd0;
            o_ent.yaw      = 8'd0;
        end else begin
            o_ent.id       = r_id;
            o_ent.distance = r_dist;
            o_ent.pitch    = r_pitch;
            o_ent.yaw      = i_tdata;
        end
        o_push   = accept && (frame_end || (in_rec && off == 3'd3));
        o_tready = !i_qstat.full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= POS_W'(BASE_LEN);
            r_count <= '0;
            r_err   <= 1'b0;
        end else if (accept) begin
            r_count <= cnt_eff;
            if (frame_end) begin
                r_pos <= '0;
                r_len <= POS_W'(BASE_LEN);
                r_err <= 1'b0;
            end else begin
                r_pos <= pos_inc;
                r_len <= len_eff;
                r_err <= err_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_rec) begin
            case (off)
                3'd0:    r_id    <= i_tdata;
                3'd1:    r_dist  <= i_tdata;
                3'd2:    r_pitch <= i_tdata;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/rftt_queue.sv]
// Short FIFO of target records and frame-end marks between parser and updater.
// Depends on rftt_pkg.
`default_nettype none

module rftt_queue import rftt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_ent,
    input  wire logic  i_pop,
    output t_qent      o_ent,
    output t_qstat     o_qstat
);

    t_qent           r_mem [QDEPTH];
    logic [QA_W-1:0] r_wr, r_rd;
    logic [QC_W-1:0] r_cnt;
    logic            do_push, do_pop;

    always_comb begin
        o_qstat.full  = r_cnt == QC_W'(QDEPTH);
        o_qstat.empty = r_cnt == '0;
        do_push       = i_push && !o_qstat.full;
        do_pop        = i_pop && !o_qstat.empty;
        o_ent         = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + QA_W'(1);
            if (do_pop)  r_rd <= r_rd + QA_W'(1);
            r_cnt <= r_cnt + QC_W'(do_push) - QC_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_ent;
    end

endmodule

`default_nettype wire

[design/rftt_back.sv]
// Slot table updater and reporter: applies queued targets, walks all slots at frame end.
// Depends on rftt_pkg; drains rftt_queue, drives the output register.
`default_nettype none

module rftt_back import rftt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_qent i_ent,
    input  wire t_qstat i_qstat,
    output logic       o_pop,
    output logic       o_tvalid,
    input  wire logic  i_tready,
    output logic [63:0] o_tdata,
    output logic       o_tlast
);

    t_bstate r_state, n_state;

    logic [NUM_SLOTS-1:0] r_named, r_present, r_prev_valid;
    logic [23:0]          r_cur  [NUM_SLOTS];
    logic [23:0]          r_prev [NUM_SLOTS];
    logic                 r_err;
    logic [7:0]           r_count;
    logic [SIDX_W-1:0]    r_k;
    logic                 r_ovalid, r_olast;
    t_out                 r_oword;

    logic              load, k_last, id_ok;
    logic [SIDX_W-1:0] id;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        load    = 1'b0;
        id      = i_ent.id[SIDX_W-1:0];
        id_ok   = i_ent.id < 8'(NUM_SLOTS);
        k_last  = r_k == SIDX_W'(NUM_SLOTS - 1);
        unique case (r_state)
            B_APPLY: begin
                o_pop = !i_qstat.empty;
                if (o_pop && i_ent.is_end) n_state = B_REPORT;
            end
            B_REPORT: begin
                load = !r_ovalid || i_tready;
                if (load && k_last) n_state = B_APPLY;
            end
            default: n_state = B_APPLY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_APPLY;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_named      <= '0;
            r_present    <= '0;
            r_prev_valid <= '0;
            r_err        <= 1'b0;
            r_count      <= '0;
            r_k          <= '0;
            r_ovalid     <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_cur[i]  <= '0;
                r_prev[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                if (i_ent.is_end) begin
                    r_count <= i_ent.id;
                    r_err   <= r_err | i_ent.distance[0];
                end else if (!id_ok) begin
                    r_err <= 1'b1;
                end else begin
                    r_named[id]   <= 1'b1;
                    r_present[id] <= 1'b1;
                    r_cur[id]     <= {i_ent.distance, i_ent.pitch, i_ent.yaw};
                    if (r_present[id]) begin
                        r_prev_valid[id] <= 1'b1;
                        r_prev[id]       <= r_cur[id];
                    end
                end
            end
            if (load) begin
                r_ovalid     <= 1'b1;
                r_present[r_k] <= r_named[r_k];
                if (k_last) begin
                    r_k     <= '0;
                    r_named <= '0;
                    r_err   <= 1'b0;
                end else begin
                    r_k <= r_k + SIDX_W'(1);
                end
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_olast                   <= k_last;
            r_oword.pad               <= 1'b0;
            r_oword.frame_error       <= r_err;
            r_oword.frame_count_field <= r_count;
            r_oword.prev_distance     <= r_prev[r_k][23:16];
            r_oword.prev_pitch        <= r_prev[r_k][15:8];
            r_oword.prev_yaw          <= r_prev[r_k][7:0];
            r_oword.prev_valid        <= r_prev_valid[r_k];
            r_oword.distance          <= r_cur[r_k][23:16];
            r_oword.pitch             <= r_cur[r_k][15:8];
            r_oword.yaw               <= r_cur[r_k][7:0];
            r_oword.present           <= r_named[r_k];
            r_oword.slot              <= 4'(r_k);
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_oword;
    assign o_tlast  = r_olast;

endmodule

`default_nettype wire

[test/rftt_report_checker.sv]
// Slot report checker for the radar frame target tracker: tracks the byte
// stream, predicts every slot report at frame end and compares each word.
// Depends on rftt_pkg for sizes, frame constants and the report layout.
`default_nettype none

module rftt_report_checker import rftt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [63:0] i_m_tdata,   // t_out layout, slot in the lowest bits
    input  wire logic        i_m_tlast,   // last
    output int               o_mismatches,
    output int               o_reports_due,
    output int               o_reports_seen
);

    typedef struct packed {
        logic [7:0] distance;
        logic [7:0] pitch;
        logic [7:0] yaw;
    } t_pos;

    typedef struct packed {
        logic [7:0] id;
        t_pos       pos;
    } t_rec;

    typedef struct packed {
        t_out word;
        logic last;
    } t_report;

    logic [11:0] byte_pos;
    logic [11:0] frame_len;
    logic [7:0]  count_byte;
    logic        err_seen;
    t_rec        staged[MAX_STAGED];
    logic        slot_on[NUM_SLOTS];
    t_pos        cur_pos[NUM_SLOTS];
    logic        prev_on[NUM_SLOTS];
    t_pos        prev_pos[NUM_SLOTS];

    t_report     reports_due[$];
    int          mismatches;
    int          reports_seen;

    task automatic note_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got, int idx);
        if (want !== got)
            note_mismatch($sformatf("report %0d %s: want %0h got %0h", idx, name, want, got));
    endtask

    task automatic reset_tracker();
        byte_pos   = '0;
        frame_len  = 12'(BASE_LEN);
        count_byte = '0;
        err_seen   = 1'b0;
        for (int i = 0; i < MAX_STAGED; i++)
            staged[i] = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_on[k]  = 1'b0;
            cur_pos[k]  = '0;
            prev_on[k]  = 1'b0;
            prev_pos[k] = '0;
        end
        reports_due.delete();
    endtask

    // Apply staged records in frame order, then queue one report per slot.
    task automatic close_frame();
        logic    named[NUM_SLOTS];
        logic    err;
        int      n;
        int      id;
        t_report r;
        err = err_seen;
        n = (count_byte > MAX_STAGED) ? MAX_STAGED : int'(count_byte);
        for (int k = 0; k < NUM_SLOTS; k++)
            named[k] = 1'b0;
        for (int i = 0; i < n; i++) begin
            id = int'(staged[i].id);
            if (id >= NUM_SLOTS) begin
                err = 1'b1;
            end else begin
                named[id] = 1'b1;
                if (slot_on[id]) begin
                    prev_on[id]  = 1'b1;
                    prev_pos[id] = cur_pos[id];
                end
                slot_on[id] = 1'b1;
                cur_pos[id] = staged[i].pos;
            end
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (!named[k])
                slot_on[k] = 1'b0;
            r = '0;
            r.word.slot              = 4'(k);
            r.word.present           = slot_on[k];
            r.word.distance          = cur_pos[k].distance;
            r.word.pitch             = cur_pos[k].pitch;
            r.word.yaw               = cur_pos[k].yaw;
            r.word.prev_valid        = prev_on[k];
            r.word.prev_distance     = prev_pos[k].distance;
            r.word.prev_pitch        = prev_pos[k].pitch;
            r.word.prev_yaw          = prev_pos[k].yaw;
            r.word.frame_count_field = count_byte;
            r.word.frame_error       = err;
            r.last                   = (k == NUM_SLOTS - 1);
            reports_due.push_back(r);
        end
    endtask

    task automatic absorb_byte(logic [7:0] b);
        int rel;
        if (byte_pos == COUNT_POS) begin
            count_byte = b;
            frame_len  = 12'(BASE_LEN + REC_LEN * int'(b));
            if (b > MAX_STAGED)
                err_seen = 1'b1;
        end
        if (byte_pos >= REC_START) begin
            rel = int'(byte_pos) - REC_START;
            if (rel / REC_LEN < MAX_STAGED) begin
                case (rel % REC_LEN)
                    0: staged[rel / REC_LEN].id           = b;
                    1: staged[rel / REC_LEN].pos.distance = b;
                    2: staged[rel / REC_LEN].pos.pitch    = b;
                    3: staged[rel / REC_LEN].pos.yaw      = b;
                    default: ;
                endcase
            end
        end
        byte_pos = byte_pos + 12'd1;
        if (byte_pos == frame_len) begin
            close_frame();
            byte_pos  = '0;
            frame_len = 12'(BASE_LEN);
            err_seen  = 1'b0;
        end
    endtask

    task automatic check_report();
        t_report want;
        t_out    got;
        int      idx;
        got = t_out'(i_m_tdata);
        idx = reports_seen;
        reports_seen++;
        if (reports_due.size() == 0) begin
            note_mismatch($sformatf("report %0d arrived with none due (tdata %h)",
                                    idx, i_m_tdata));
        end else begin
            want = reports_due.pop_front();
            compare_field("slot", want.word.slot, got.slot, idx);
            compare_field("present", want.word.present, got.present, idx);
            compare_field("distance", want.word.distance, got.distance, idx);
            compare_field("pitch", want.word.pitch, got.pitch, idx);
            compare_field("yaw", want.word.yaw, got.yaw, idx);
            compare_field("prev_valid", want.word.prev_valid, got.prev_valid, idx);
            compare_field("prev_distance", want.word.prev_distance, got.prev_distance, idx);
            compare_field("prev_pitch", want.word.prev_pitch, got.prev_pitch, idx);
            compare_field("prev_yaw", want.word.prev_yaw, got.prev_yaw, idx);
            compare_field("frame_count_field", want.word.frame_count_field,
                          got.frame_count_field, idx);
            compare_field("frame_error", want.word.frame_error, got.frame_error, idx);
            compare_field("pad", want.word.pad, got.pad, idx);
            compare_field("last", want.last, i_m_tlast, idx);
        end
    endtask

    initial begin
        mismatches   = 0;
        reports_seen = 0;
        reset_tracker();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_tracker();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_report();
            if (i_s_tvalid && i_s_tready)
                absorb_byte(i_s_tdata);
        end
        o_mismatches   <= mismatches;
        o_reports_due  <= reports_due.size();
        o_reports_seen <= reports_seen;
    end

endmodule

`default_nettype wire

[test/radar_frame_target_tracker_test.sv]
// Testbench top for the radar frame target tracker: drives radar frames,
// idles both channels, and gives the verdict from rftt_report_checker.
// Depends on rftt_pkg, radar_frame_target_tracker and rftt_report_checker.
`default_nettype none

module radar_frame_target_tracker_test import rftt_pkg::*; ();

    localparam int RANDOM_BYTES = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        FK_PLAIN,
        FK_DUP,
        FK_BAD_ID,
        FK_OVERFLOW
    } t_frame_kind;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    logic        m_tlast;

    int mismatches;
    int reports_due;
    int reports_seen;
    int phase = 0;
    int bytes_sent = 0;
    int frames_sent = 0;
    int quiet_cycles = 0;

    radar_frame_target_tracker u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    rftt_report_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tlast      (m_tlast),
        .o_mismatches   (mismatches),
        .o_reports_due  (reports_due),
        .o_reports_seen (reports_seen)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Stalled for %0d cycles, %0d reports due", quiet_cycles, reports_due);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: idle mix per phase, one long hold-off when the last phase opens.
    initial begin : receiver
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge clk);
            if (phase == 2 && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= ((phase == 0) ? 79 : (phase == 1) ? 9 : 0));
            end
        end
    end

    task automatic push_byte(logic [7:0] b);
        while ($urandom_range(99) < ((phase == 0) ? 9 : (phase == 1) ? 79 : 0)) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_fixed_frame(int count, logic [7:0] fill, logic [7:0] id);
        for (int pos = 0; pos < BASE_LEN + REC_LEN * count; pos++) begin
            if (pos == COUNT_POS)
                push_byte(8'(count));
            else if (pos >= REC_START && (pos - REC_START) % REC_LEN == 0)
                push_byte(id);
            else
                push_byte(fill);
        end
        frames_sent++;
    endtask

    task automatic send_frame(t_frame_kind kind);
        int         count;
        int         rel;
        int         bad_rec;
        logic [7:0] b;
        case (kind)
            FK_PLAIN:  count = $urandom_range(4);
            FK_DUP:    count = $urandom_range(5, 2);
            FK_BAD_ID: count = $urandom_range(4, 1);
            default:   count = $urandom_range(MAX_STAGED + 4, MAX_STAGED + 1);
        endcase
        bad_rec = (count > 0) ? $urandom_range(count - 1) : 0;
        for (int pos = 0; pos < BASE_LEN + REC_LEN * count; pos++) begin
            b   = 8'($urandom);
            rel = pos - REC_START;
            if (pos == COUNT_POS) begin
                b = 8'(count);
            end else if (rel >= 0 && rel % REC_LEN == 0) begin
                case (kind)
                    FK_DUP:    b = 8'($urandom_range(1));
                    FK_BAD_ID: b = (rel / REC_LEN == bad_rec) ?
                                   8'($urandom_range(255, NUM_SLOTS)) :
                                   8'($urandom_range(NUM_SLOTS - 1));
                    default:   b = ($urandom_range(9) == 0) ? 8'($urandom) :
                                   8'($urandom_range(NUM_SLOTS - 1));
                endcase
            end
            push_byte(b);
        end
        frames_sent++;
    endtask

    initial begin : stimulus
        int          pick;
        t_frame_kind kind;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes: highest slot with all-ones bytes, then an empty all-zero frame.
        send_fixed_frame(1, 8'hFF, 8'(NUM_SLOTS - 1));
        send_fixed_frame(0, 8'h00, 8'h00);

        send_frame(FK_DUP);
        send_frame(FK_BAD_ID);
        send_frame(FK_OVERFLOW);
        send_frame(FK_PLAIN);
        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent >= (2 * RANDOM_BYTES) / 3)
                phase <= 2;
            else if (bytes_sent >= RANDOM_BYTES / 3)
                phase <= 1;
            pick = $urandom_range(99);
            if (pick < 60)
                kind = FK_PLAIN;
            else if (pick < 75)
                kind = FK_DUP;
            else if (pick < 87)
                kind = FK_BAD_ID;
            else
                kind = FK_OVERFLOW;
            send_frame(kind);
        end
        phase <= 2;
        send_frame(FK_OVERFLOW);
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d frames: duplicate, out-of-range and overflow ids,",
                 bytes_sent, frames_sent);
        $display("extreme byte values and a %0d-cycle output hold-off; %0d slot reports checked",
                 HOLD_CYCLES, reports_seen);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/rftt_pkg.sv
design/rftt_front.sv
design/rftt_queue.sv
design/rftt_back.sv
design/radar_frame_target_tracker.sv
test/rftt_report_checker.sv
test/radar_frame_target_tracker_test.sv
